// ===== rtl/cdll_pkg.sv =====
// cdll_pkg: shared types and constants of the circular doubly linked list unit
// no dependencies; used by the interfaces and the top level

package cdll_pkg;

    localparam int NODE_COUNT_DEF = 256;

    localparam logic [1:0] MODE_APPEND      = 2'd0;
    localparam logic [1:0] MODE_REMOVE_HEAD = 2'd1;
    localparam logic [1:0] MODE_REMOVE_NODE = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WR1,
        S_WR2
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND_FIRST,
        OP_APPEND,
        OP_UNLINK
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic       node_present;
        logic [7:0] node_index;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [7:0] removed_node;
        logic       removed_valid;
        logic       list_empty;
        logic [7:0] head_node;
    } t_rsp;

endpackage

// ===== rtl/cdll_if.sv =====
// cdll_req_if, cdll_rsp_if: valid/ready channels of the linked list unit
// depends on cdll_pkg for the payload types

interface cdll_req_if;
    import cdll_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdll_rsp_if;
    import cdll_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cdll_ram.sv =====
// cdll_ram: generic single write port, single read port ram with registered read
// no dependencies

module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/circular_doubly_linked_list_unit.sv =====
// circular_doubly_linked_list_unit: one circular doubly linked list over a node pool
// depends on cdll_pkg, cdll_req_if, cdll_rsp_if and cdll_ram

// The next and prev links live in two rams, one per link kind, each with one write
// port and a registered read. Every item passes through four states: the accept
// state, a read state for the links of the nodes involved, and two write states,
// since an append or an unlink changes up to two entries of each link ram and each
// ram takes one write per cycle. The result goes into an output register, so the
// next item is accepted while the previous result still waits; the last write
// state holds only when that register is full and not being taken. Node indices
// are taken modulo NODE_COUNT. Links of a node never written are undefined; there
// is no clearing pass after reset.
module circular_doubly_linked_list_unit #(
    parameter int NODE_COUNT = cdll_pkg::NODE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdll_req_if.sink          i_req,
    cdll_rsp_if.source        o_rsp
);

    import cdll_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);

    // 8-bit index modulo the pool size, as a constant lookup table
    function automatic logic [IW-1:0] node_mod(input logic [7:0] v);
        logic [IW-1:0] rem;
        rem = '0;
        for (int k = 0; k < 256; k++) begin
            if (v == 8'(k)) begin
                rem = IW'(k % NODE_COUNT);
            end
        end
        return rem;
    endfunction

    t_state          r_state, n_state;
    t_op             r_op;
    logic [IW-1:0]   r_node;
    logic [IW-1:0]   r_head, n_head;
    logic            r_empty, n_empty;
    logic            r_status;
    logic            r_rvalid;
    logic [IW-1:0]   r_removed;
    logic            r_out_valid;
    t_rsp            r_out;

    logic            accept;
    logic            out_free;
    logic [IW-1:0]   req_node;

    logic            rd_en;
    logic [IW-1:0]   prev_rd_addr;
    logic [IW-1:0]   prev_rd_data;
    logic [IW-1:0]   next_rd_data;
    logic            next_wr_en, prev_wr_en;
    logic [IW-1:0]   next_wr_addr, prev_wr_addr;
    logic [IW-1:0]   next_wr_data, prev_wr_data;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign req_node = node_mod(i_req.data.node_index);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_WR1;
            S_WR1:   n_state = S_WR2;
            S_WR2:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ram controls and handshake
    always_comb begin
        i_req.ready  = (r_state == S_IDLE);
        rd_en        = (r_state == S_READ);
        prev_rd_addr = (r_op == OP_APPEND) ? r_head : r_node;
        next_wr_en   = 1'b0;
        prev_wr_en   = 1'b0;
        next_wr_addr = r_node;
        prev_wr_addr = r_node;
        next_wr_data = r_node;
        prev_wr_data = r_node;
        case (r_state)
            S_WR1: begin
                case (r_op)
                    OP_APPEND_FIRST: begin
                        next_wr_en = 1'b1;
                        prev_wr_en = 1'b1;
                    end
                    OP_APPEND: begin
                        next_wr_en   = 1'b1;
                        next_wr_data = r_head;
                        prev_wr_en   = 1'b1;
                        prev_wr_data = prev_rd_data;
                    end
                    OP_UNLINK: begin
                        // bridge the neighbors over the node
                        next_wr_en   = 1'b1;
                        next_wr_addr = prev_rd_data;
                        next_wr_data = next_rd_data;
                        prev_wr_en   = 1'b1;
                        prev_wr_addr = next_rd_data;
                        prev_wr_data = prev_rd_data;
                    end
                    default: ;
                endcase
            end
            S_WR2: begin
                case (r_op)
                    OP_APPEND: begin
                        next_wr_en   = out_free;
                        next_wr_addr = prev_rd_data;
                        prev_wr_en   = out_free;
                        prev_wr_addr = r_head;
                    end
                    OP_UNLINK: begin
                        // removed node points at itself
                        next_wr_en = out_free;
                        prev_wr_en = out_free;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // list head after the item
    always_comb begin
        n_head  = r_head;
        n_empty = r_empty;
        case (r_op)
            OP_APPEND_FIRST: begin
                n_head  = r_node;
                n_empty = 1'b0;
            end
            OP_UNLINK: begin
                if (r_head == r_node) begin
                    if (next_rd_data == r_node) begin
                        n_head  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_head = next_rd_data;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NONE;
            r_head      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_op <= OP_NONE;
                case (i_req.data.mode)
                    MODE_APPEND: begin
                        if (i_req.data.node_present) begin
                            r_op <= r_empty ? OP_APPEND_FIRST : OP_APPEND;
                        end
                    end
                    MODE_REMOVE_HEAD: begin
                        if (!r_empty) r_op <= OP_UNLINK;
                    end
                    MODE_REMOVE_NODE: begin
                        if (!r_empty && i_req.data.node_present) r_op <= OP_UNLINK;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_WR2 && out_free) begin
                r_head      <= n_head;
                r_empty     <= n_empty;
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_node    <= req_node;
            r_status  <= STATUS_OK;
            r_rvalid  <= 1'b0;
            r_removed <= '0;
            case (i_req.data.mode)
                MODE_REMOVE_HEAD: begin
                    r_node <= r_head;
                    if (r_empty) begin
                        r_status <= STATUS_ERR;
                    end else begin
                        r_rvalid  <= 1'b1;
                        r_removed <= r_head;
                    end
                end
                MODE_REMOVE_NODE: begin
                    if (r_empty || !i_req.data.node_present) r_status <= STATUS_ERR;
                end
                default: ;
            endcase
        end
        if (r_state == S_WR2 && out_free) begin
            r_out.status        <= r_status;
            r_out.removed_node  <= 8'(r_removed);
            r_out.removed_valid <= r_rvalid;
            r_out.list_empty    <= n_empty;
            r_out.head_node     <= n_empty ? 8'd0 : 8'(n_head);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    cdll_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_wr_en),
        .i_wr_addr (next_wr_addr),
        .i_wr_data (next_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_node),
        .o_rd_data (next_rd_data)
    );

    cdll_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_wr_en),
        .i_wr_addr (prev_wr_addr),
        .i_wr_data (prev_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (prev_rd_addr),
        .o_rd_data (prev_rd_data)
    );

endmodule
